/* rtl/adlp_pkg.sv */
// Shared constants and types for the ASCII duty line parser.
package adlp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned DUTY_W  = 8;
   localparam int unsigned SPEED_W = 11;
   localparam int unsigned MAG_W   = 7;

   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [MAG_W-1:0] MAG_SAT  = 7'd101;
   localparam logic [MAG_W-1:0] DUTY_MAX = 7'd100;

   // Line-end outcome handed from the line parser to the response stage.
   typedef struct packed {
      logic                     emit;
      logic signed [DUTY_W-1:0] duty;
   } line_result_type;

endpackage

/* rtl/ascii_duty_line_parser.sv */
// Top level of the ASCII duty line parser.
//
// Usage: feed received command bytes on the req_ channel, one per cycle.
// Each line (ended by CR or LF) is read like atoi: leading blanks are
// skipped, an optional sign, then decimal digits; the first other character
// ends the number. Only the first MAX_LINE_CHARS characters of a line count.
// A non-empty line yields one response on the rsp_ channel carrying the
// duty clamped to -100..100 and the motor speed (duty times ten); an empty
// line yields nothing.
//
// Flow: an accepted byte is registered in the input register; from there it
// updates the line state and, if it ends a line, loads the response
// register that drives rsp_. Throughput: one byte per cycle unless req_stall is high.
// Reset empties the input register and the response register and clears
// the line state.
// When the receiver stalls, the response holds; bytes that do not end a
// line keep flowing, and a line-ending byte waits in the input register
// (stalling req_) until the response slot frees up.
module ascii_duty_line_parser #(
   parameter int unsigned MAX_LINE_CHARS = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [adlp_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [adlp_pkg::DUTY_W-1:0]   rsp_duty_percent,
   output logic signed [adlp_pkg::SPEED_W-1:0]  rsp_motor_speed
);

   logic                          in_valid_ff, in_valid_in;
   logic [adlp_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_go;
   logic                          load_rsp;
   adlp_pkg::line_result_type     line_result;

   // Hold the byte only when it ends a line and the response slot is busy.
   assign in_go     = !(line_result.emit && rsp_valid && rsp_stall);
   assign req_stall = in_valid_ff && !in_go;
   assign load_rsp  = line_result.emit && in_go;

   // Refill the input register whenever it is empty or advancing.
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   adlp_line #(
      .MAX_LINE_CHARS(MAX_LINE_CHARS)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .char_valid (in_valid_ff),
      .char_fire  (in_valid_ff && in_go),
      .char_byte  (in_byte_ff),
      .result     (line_result)
   );

   adlp_rsp u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load             (load_rsp),
      .duty             (line_result.duty),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_motor_speed  (rsp_motor_speed)
   );

endmodule

/* rtl/adlp_line.sv */
// Line state tracker: atoi-style parse of one character per request.
module adlp_line #(
   parameter int unsigned MAX_LINE_CHARS = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              char_valid,
   input  logic                              char_fire,
   input  logic [adlp_pkg::BYTE_W-1:0]       char_byte,
   output adlp_pkg::line_result_type         result
);

   localparam int unsigned CNT_W = $clog2(MAX_LINE_CHARS + 1);

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   logic [CNT_W-1:0]           count_ff, count_in;
   phase_type                  phase_ff, phase_in;
   logic                       neg_ff, neg_in;
   logic [adlp_pkg::MAG_W-1:0] mag_ff, mag_in;

   logic                       is_eol, is_blank, is_digit;
   logic [3:0]                 digit;
   logic [9:0]                 mag_sum;
   logic [adlp_pkg::MAG_W-1:0] mag_add, mag_clamped;
   logic [adlp_pkg::DUTY_W-1:0] mag_wide;

   assign is_eol   = (char_byte == adlp_pkg::CHAR_CR) || (char_byte == adlp_pkg::CHAR_LF);
   assign is_blank = (char_byte == adlp_pkg::CHAR_SPACE) || (char_byte == adlp_pkg::CHAR_TAB)
                  || (char_byte == adlp_pkg::CHAR_VT) || (char_byte == adlp_pkg::CHAR_FF);
   assign is_digit = (char_byte >= adlp_pkg::CHAR_ZERO) && (char_byte <= adlp_pkg::CHAR_NINE);
   assign digit    = char_byte[3:0];

   // mag * 10 + digit, saturating
   assign mag_sum = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0} + {6'd0, digit};
   assign mag_add = (mag_sum > {3'd0, adlp_pkg::MAG_SAT}) ? adlp_pkg::MAG_SAT
                                                          : mag_sum[adlp_pkg::MAG_W-1:0];

   assign mag_clamped = (mag_ff > adlp_pkg::DUTY_MAX) ? adlp_pkg::DUTY_MAX : mag_ff;
   assign mag_wide    = {1'b0, mag_clamped};

   always_comb begin
      result.emit = char_valid && is_eol && (count_ff != '0);
      result.duty = neg_ff ? -$signed(mag_wide) : $signed(mag_wide);
   end

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      if (char_fire) begin
         if (is_eol) begin
            count_in = '0;
            phase_in = PH_SKIP;
            neg_in   = 1'b0;
            mag_in   = '0;
         end else if (count_ff < CNT_W'(MAX_LINE_CHARS)) begin
            count_in = count_ff + 1'b1;
            unique case (phase_ff)
               PH_SKIP: begin
                  if (is_blank) begin
                     phase_in = PH_SKIP;
                  end else if (char_byte == adlp_pkg::CHAR_PLUS) begin
                     phase_in = PH_DIGITS;
                  end else if (char_byte == adlp_pkg::CHAR_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_DIGITS;
                  end else if (is_digit) begin
                     mag_in   = mag_add;
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     mag_in = mag_add;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

endmodule

/* rtl/adlp_rsp.sv */
// Response register: scales duty to speed and holds the result while stalled.
module adlp_rsp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic signed [adlp_pkg::DUTY_W-1:0]    duty,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [adlp_pkg::DUTY_W-1:0]    rsp_duty_percent,
   output logic signed [adlp_pkg::SPEED_W-1:0]   rsp_motor_speed
);

   logic                                 valid_ff, valid_in;
   logic signed [adlp_pkg::DUTY_W-1:0]   duty_ff;
   logic signed [adlp_pkg::SPEED_W-1:0]  speed_ff, speed_in, duty_ext;

   // speed = duty * 8 + duty * 2
   assign duty_ext = adlp_pkg::SPEED_W'(duty);
   assign speed_in = (duty_ext <<< 3) + (duty_ext <<< 1);
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         duty_ff  <= duty;
         speed_ff <= speed_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_duty_percent = duty_ff;
   assign rsp_motor_speed  = speed_ff;

endmodule

/* dv/ascii_duty_line_parser_tb.sv */
// Self-checking testbench for the ASCII duty line parser: byte stream in, duty commands out.
module ascii_duty_line_parser_tb;

   localparam int unsigned LINE_CHAR_LIMIT = 31;
   localparam int unsigned DIRECTED_BYTES  = 25;
   localparam int unsigned RANDOM_BYTES    = 1500;
   localparam int unsigned LONG_HOLD       = 300;   // receiver hold-off, in cycles
   localparam int unsigned HOLD_AFTER_RSPS = 40;    // responses before the long hold-off
   localparam int unsigned QUIET_LIMIT     = 2000;  // cycles with no request or response moving
   localparam int unsigned DRAIN_CYCLES    = 20;    // settle time after the last response
   localparam int unsigned MAX_PRINTED     = 100;   // keep the log short on a broken build

   localparam logic [adlp_pkg::BYTE_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [adlp_pkg::BYTE_W-1:0] CHAR_HIGH = 8'hFF;

   // Phase of the atoi-style scan within the current line.
   typedef enum logic [1:0] {SCAN_BLANKS, SCAN_DIGITS, SCAN_DONE} scan_phase_type;

   // One motor command as it leaves the block.
   typedef struct packed {
      logic signed [adlp_pkg::DUTY_W-1:0]  duty;
      logic signed [adlp_pkg::SPEED_W-1:0] speed;
   } motor_cmd_type;

   // One pending request; drain_first holds it back until every response is in.
   typedef struct {
      logic [adlp_pkg::BYTE_W-1:0] rx_byte;
      bit                          drain_first;
   } rx_request_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   logic [adlp_pkg::BYTE_W-1:0]          req_rx_byte = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall   = 1'b0;
   logic signed [adlp_pkg::DUTY_W-1:0]   rsp_duty_percent;
   logic signed [adlp_pkg::SPEED_W-1:0]  rsp_motor_speed;

   // Line state of the predictor.
   int unsigned                  line_chars      = 0;
   scan_phase_type               scan_phase      = SCAN_BLANKS;
   logic                         line_negative   = 1'b0;
   logic [adlp_pkg::MAG_W-1:0]   line_mag        = '0;

   motor_cmd_type      duty_expected_q[$];
   rx_request_type     rx_pending_q[$];
   bit                 drain_next      = 1'b0;
   int unsigned        lines_predicted = 0;  // responses owed so far, updated by the driver
   int unsigned        bytes_accepted  = 0;
   int unsigned        responses_seen  = 0;  // updated by the monitor with nonblocking writes
   int unsigned        mismatch_count  = 0;
   int unsigned        send_idle       = 0;
   int unsigned        stall_left      = 0;
   bit                 long_hold_done  = 1'b0;
   int unsigned        quiet_cycles    = 0;

   ascii_duty_line_parser #(
      .MAX_LINE_CHARS(LINE_CHAR_LIMIT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_motor_speed  (rsp_motor_speed)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: line parsing, saturation, clamping and the speed scaling
   // ---------------------------------------------------------------------

   function automatic bit is_blank_char(logic [adlp_pkg::BYTE_W-1:0] c);
      return c == adlp_pkg::CHAR_SPACE || c == adlp_pkg::CHAR_TAB
          || c == adlp_pkg::CHAR_VT || c == adlp_pkg::CHAR_FF;
   endfunction

   function automatic bit is_digit_char(logic [adlp_pkg::BYTE_W-1:0] c);
      return c >= adlp_pkg::CHAR_ZERO && c <= adlp_pkg::CHAR_NINE;
   endfunction

   // Fold in one decimal digit; stick at the saturation value instead of wrapping.
   task automatic accumulate_digit(logic [adlp_pkg::BYTE_W-1:0] c);
      int unsigned sum;
      sum = int'(line_mag) * 10 + int'(c - adlp_pkg::CHAR_ZERO);
      line_mag = (sum > int'(adlp_pkg::MAG_SAT)) ? adlp_pkg::MAG_SAT
                                                 : sum[adlp_pkg::MAG_W-1:0];
   endtask

   // Advance the line state by one accepted byte; queue a command at a line end.
   task automatic predict_duty(logic [adlp_pkg::BYTE_W-1:0] c);
      int            value;
      motor_cmd_type cmd;
      if (c == adlp_pkg::CHAR_CR || c == adlp_pkg::CHAR_LF) begin
         // an empty line owes nothing and leaves the state alone
         if (line_chars != 0) begin
            value = line_negative ? -int'(line_mag) : int'(line_mag);
            if (value > int'(adlp_pkg::DUTY_MAX)) value = int'(adlp_pkg::DUTY_MAX);
            if (value < -int'(adlp_pkg::DUTY_MAX)) value = -int'(adlp_pkg::DUTY_MAX);
            cmd.duty  = value[adlp_pkg::DUTY_W-1:0];
            value     = value * 10;
            cmd.speed = value[adlp_pkg::SPEED_W-1:0];
            duty_expected_q.push_back(cmd);
            lines_predicted++;
            line_chars    = 0;
            scan_phase    = SCAN_BLANKS;
            line_negative = 1'b0;
            line_mag      = '0;
         end
      end else if (line_chars < LINE_CHAR_LIMIT) begin
         // past the character limit, drop everything up to the line end
         line_chars++;
         case (scan_phase)
            SCAN_BLANKS: begin
               if (c == adlp_pkg::CHAR_PLUS) begin
                  scan_phase = SCAN_DIGITS;
               end else if (c == adlp_pkg::CHAR_MINUS) begin
                  line_negative = 1'b1;
                  scan_phase    = SCAN_DIGITS;
               end else if (is_digit_char(c)) begin
                  accumulate_digit(c);
                  scan_phase = SCAN_DIGITS;
               end else if (!is_blank_char(c)) begin
                  scan_phase = SCAN_DONE;
               end
            end
            SCAN_DIGITS: begin
               if (is_digit_char(c)) accumulate_digit(c);
               else scan_phase = SCAN_DONE;
            end
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_byte(logic [adlp_pkg::BYTE_W-1:0] c);
      rx_request_type r;
      r.rx_byte     = c;
      r.drain_first = drain_next;
      drain_next    = 1'b0;
      rx_pending_q.push_back(r);
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   function automatic logic [adlp_pkg::BYTE_W-1:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return adlp_pkg::CHAR_SPACE;
         1:       return adlp_pkg::CHAR_TAB;
         2:       return adlp_pkg::CHAR_VT;
         default: return adlp_pkg::CHAR_FF;
      endcase
   endfunction

   function automatic logic [adlp_pkg::BYTE_W-1:0] pick_digit();
      return adlp_pkg::CHAR_ZERO + adlp_pkg::BYTE_W'($urandom_range(0, 9));
   endfunction

   // Any byte that does not end the line.
   function automatic logic [adlp_pkg::BYTE_W-1:0] pick_junk();
      logic [adlp_pkg::BYTE_W-1:0] c;
      do c = adlp_pkg::BYTE_W'($urandom_range(0, 255));
      while (c == adlp_pkg::CHAR_CR || c == adlp_pkg::CHAR_LF);
      return c;
   endfunction

   // Idle run length: mostly none, often short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Queue one random line. Most are well formed (blanks, sign, digits, junk, line end);
   // some pad with blanks right up to and past the character limit; a few are raw noise.
   task automatic queue_random_line();
      int unsigned kind;
      int unsigned pad;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) queue_byte(adlp_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
         if (kind < 16) pad = $urandom_range(LINE_CHAR_LIMIT - 5, LINE_CHAR_LIMIT + 3);
         else pad = $urandom_range(0, 3);
         repeat (pad) queue_byte(pick_blank());
         case ($urandom_range(0, 3))
            0:       queue_byte(adlp_pkg::CHAR_PLUS);
            1:       queue_byte(adlp_pkg::CHAR_MINUS);
            default: ;
         endcase
         repeat ($urandom_range(0, 4)) queue_byte(pick_digit());
         repeat ($urandom_range(0, 2)) queue_byte(pick_junk());
         case ($urandom_range(0, 2))
            0:       queue_byte(adlp_pkg::CHAR_CR);
            1:       queue_byte(adlp_pkg::CHAR_LF);
            default: begin
               queue_byte(adlp_pkg::CHAR_CR);
               queue_byte(adlp_pkg::CHAR_LF);
            end
         endcase
      end
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: predict on acceptance, hold while stalled, then either
   // idle for the drawn gap or load the next pending byte.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      rx_request_type nxt;
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= '0;
         send_idle    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_duty(req_rx_byte);
            bytes_accepted++;
         end
         // leave a stalled request untouched
         if (!(req_valid && req_stall)) begin
            if (send_idle != 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (rx_pending_q.size() != 0 &&
                         !(rx_pending_q[0].drain_first && lines_predicted != responses_seen)) begin
               nxt = rx_pending_q.pop_front();
               req_valid   <= 1'b1;
               req_rx_byte <= nxt.rx_byte;
               send_idle    = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each accepted command against the oldest
   // expectation, then decide the stall for the next cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      motor_cmd_type want;
      int unsigned   run;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen <= responses_seen + 1;
            if (duty_expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response: duty %0d speed %0d",
                                         rsp_duty_percent, rsp_motor_speed));
            end else begin
               want = duty_expected_q.pop_front();
               if (rsp_duty_percent !== want.duty)
                  report_mismatch($sformatf("duty_percent %0d, expected %0d",
                                            rsp_duty_percent, want.duty));
               if (rsp_motor_speed !== want.speed)
                  report_mismatch($sformatf("motor_speed %0d, expected %0d",
                                            rsp_motor_speed, want.speed));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && responses_seen >= HOLD_AFTER_RSPS) begin
            // hold off once for a long stretch so a line end backs up into req_stall
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD - 1;
            rsp_stall     <= 1'b1;
         end else begin
            run        = pick_gap();
            stall_left = (run != 0) ? run - 1 : 0;
            rsp_stall <= (run != 0);
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] timeout: no request or response moved", $time);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      int unsigned bytes_total;

      // empty line: no response
      queue_byte(adlp_pkg::CHAR_LF);
      // every blank skipped, then negative zero
      queue_byte(adlp_pkg::CHAR_SPACE);
      queue_byte(adlp_pkg::CHAR_TAB);
      queue_byte(adlp_pkg::CHAR_VT);
      queue_byte(adlp_pkg::CHAR_FF);
      queue_text("-0");
      queue_byte(adlp_pkg::CHAR_CR);
      // saturation on both signs
      queue_text("+255");
      queue_byte(adlp_pkg::CHAR_LF);
      queue_text("-987");
      queue_byte(adlp_pkg::CHAR_CR);
      // NUL counts as a character but stops the number
      queue_byte(CHAR_NUL);
      queue_text("5");
      queue_byte(adlp_pkg::CHAR_LF);
      // high byte is an ordinary non-digit
      queue_byte(CHAR_HIGH);
      queue_byte(adlp_pkg::CHAR_LF);
      // sign with no digits
      queue_text("-");
      queue_byte(adlp_pkg::CHAR_CR);

      // start the random part from an empty pipeline
      drain_next = 1'b1;
      while (rx_pending_q.size() < DIRECTED_BYTES + RANDOM_BYTES) queue_random_line();
      bytes_total = rx_pending_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wait for every byte to go in and every owed command to come out
      while (bytes_accepted != bytes_total || duty_expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && duty_expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/adlp_pkg.sv
rtl/adlp_line.sv
rtl/adlp_rsp.sv
rtl/ascii_duty_line_parser.sv
dv/ascii_duty_line_parser_tb.sv
